FILE: src/utf16_to_utf8_transcoder_defines.svh
// assertion helpers shared by the transcoder modules
`ifndef UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define U16U8_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("transcoder check failed");

// next-cycle implication, checked out of reset
`define U16U8_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("transcoder check failed");

`endif

FILE: src/u16u8_pkg.sv
`timescale 1ns / 1ps
package u16u8_pkg;

    localparam int CP_W    = 21;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef logic [CP_W-1:0] t_cp;
    // byte count minus one
    typedef logic [1:0]      t_nb;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam logic [5:0]      HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0]      LOW_SURR_TAG  = 6'b110111;
    localparam logic [CP_W-1:0] SUPP_BASE     = 21'h10000;
    localparam logic [CP_W-1:0] MAX_ONE       = 21'h7f;
    localparam logic [CP_W-1:0] MAX_TWO       = 21'h7ff;
    localparam logic [CP_W-1:0] MAX_THREE     = 21'hffff;
    localparam logic [7:0]      LEAD_TWO      = 8'hc0;
    localparam logic [7:0]      LEAD_THREE    = 8'he0;
    localparam logic [7:0]      LEAD_FOUR     = 8'hf0;
    localparam logic [7:0]      CONT_MARK     = 8'h80;

    localparam t_nb NB_ONE   = 2'd0;
    localparam t_nb NB_TWO   = 2'd1;
    localparam t_nb NB_THREE = 2'd2;
    localparam t_nb NB_FOUR  = 2'd3;

    function automatic t_nb byte_count(input t_cp cp);
        t_nb nb;
        if (cp <= MAX_ONE) begin
            nb = NB_ONE;
        end else if (cp <= MAX_TWO) begin
            nb = NB_TWO;
        end else if (cp <= MAX_THREE) begin
            nb = NB_THREE;
        end else begin
            nb = NB_FOUR;
        end
        return nb;
    endfunction

    // byte idx of a code point encoded in nb+1 bytes
    function automatic logic [7:0] enc_byte(input t_cp cp, input t_nb nb, input logic [1:0] idx);
        logic [7:0] b;
        logic [1:0] pos;
        pos = nb - idx;
        if (nb == NB_ONE) begin
            b = {1'b0, cp[6:0]};
        end else if (idx == 2'd0) begin
            case (nb)
                NB_TWO:   b = LEAD_TWO   | {3'b000, cp[10:6]};
                NB_THREE: b = LEAD_THREE | {4'b0000, cp[15:12]};
                default:  b = LEAD_FOUR  | {5'b00000, cp[20:18]};
            endcase
        end else begin
            case (pos)
                2'd0:    b = CONT_MARK | {2'b00, cp[5:0]};
                2'd1:    b = CONT_MARK | {2'b00, cp[11:6]};
                default: b = CONT_MARK | {2'b00, cp[17:12]};
            endcase
        end
        return b;
    endfunction

endpackage

FILE: src/u16u8_front.sv
`timescale 1ns / 1ps
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_code_unit,
    input  logic        i_string_end,
    input  t_q_stat     i_q_stat,
    output logic        o_stall,
    output logic        o_push,
    output t_cp         o_push_cp
);

    t_cp  r_pending;
    t_cp  n_pending;
    logic accept;
    logic is_high;
    logic is_low;
    t_cp  high_val;

    assign o_stall  = i_q_stat.full;
    assign accept   = i_valid && !i_q_stat.full;
    assign is_high  = (i_code_unit[15:10] == HIGH_SURR_TAG);
    assign is_low   = (i_code_unit[15:10] == LOW_SURR_TAG);
    assign high_val = (CP_W'(i_code_unit[9:0]) << 10) + SUPP_BASE;

    always_comb begin
        o_push_cp = is_low ? (r_pending | CP_W'(i_code_unit[9:0])) : CP_W'(i_code_unit);
        o_push    = accept && !is_high;
        n_pending = r_pending;
        if (accept) begin
            // completed point or end of string clears the pending value
            n_pending = (is_high && !i_string_end) ? high_val : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

endmodule

FILE: src/u16u8_queue.sv
`timescale 1ns / 1ps
`include "utf16_to_utf8_transcoder_defines.svh"
module u16u8_queue
    import u16u8_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cp     i_push_cp,
    input  logic    i_pop,
    output t_cp     o_head_cp,
    output t_q_stat o_q_stat
);

    t_cp             r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_count;

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
        return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_head_cp      = r_mem[r_rd];
    assign o_q_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_q_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_cp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `U16U8_ASSERT_NOW(a_no_push_full, o_q_stat.full, !i_push)
    `U16U8_ASSERT_NOW(a_no_pop_empty, o_q_stat.empty, !i_pop)
    `U16U8_ASSERT_NEXT(a_count_grows, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

FILE: src/u16u8_back.sv
`timescale 1ns / 1ps
`include "utf16_to_utf8_transcoder_defines.svh"
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_stat    i_q_stat,
    input  t_cp        i_head_cp,
    input  logic       i_stall,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    t_cp        r_cp;
    t_nb        r_nb;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    t_cp        n_cp;
    t_nb        n_nb;
    logic [1:0] n_idx;
    logic       n_busy;
    logic       n_valid;
    logic [7:0] n_byte;
    logic       n_last;

    logic       out_free;
    t_nb        head_nb;

    assign out_free      = !r_valid || !i_stall;
    assign head_nb       = byte_count(i_head_cp);
    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;

    always_comb begin
        n_cp    = r_cp;
        n_nb    = r_nb;
        n_idx   = r_idx;
        n_busy  = r_busy;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (out_free) begin
            if (r_busy) begin
                // continue the point in flight
                n_byte  = enc_byte(r_cp, r_nb, r_idx);
                n_last  = (r_idx == r_nb);
                n_valid = 1'b1;
                n_idx   = r_idx + 1'b1;
                n_busy  = (r_idx != r_nb);
            end else if (!i_q_stat.empty) begin
                // lead byte straight from the queue head
                o_pop   = 1'b1;
                n_cp    = i_head_cp;
                n_nb    = head_nb;
                n_byte  = enc_byte(i_head_cp, head_nb, 2'd0);
                n_last  = (head_nb == NB_ONE);
                n_valid = 1'b1;
                n_idx   = 2'd1;
                n_busy  = (head_nb != NB_ONE);
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp   <= n_cp;
        r_nb   <= n_nb;
        r_idx  <= n_idx;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    `U16U8_ASSERT_NOW(a_idx_in_range, r_busy, (r_idx != 2'd0) && (r_idx <= r_nb))
    `U16U8_ASSERT_NOW(a_pop_only_idle, o_pop, !r_busy && out_free)

endmodule

FILE: src/utf16_to_utf8_transcoder.sv
`timescale 1ns / 1ps
// utf-16 to utf-8 transcoder
// input channel: i_valid / o_stall with i_code_unit and i_string_end, one
//   utf-16 code unit per item; i_string_end marks the last unit of a string
// output channel: o_valid / i_stall with o_out_byte and o_last_of_run, one
//   utf-8 byte per item, lead byte first, last_of_run on the final byte
// a high surrogate is held as a pending code point and gives no bytes; a low
//   surrogate that follows completes it; non-surrogate units are encoded alone
// the lead byte of an accepted unit passes through the queue and then the output register before it is shown
// each unit gives 1 to 4 output bytes, the number of utf-8 bytes it completes
//   (a high surrogate gives none); the output register moves one byte a cycle
//   while i_stall is low and sets the rate
// a two-entry queue of code points sits between the front classifier and the
//   byte serializer, so the input keeps flowing while bytes wait to be taken
// when the receiver stalls, the output byte holds; the queue fills and then
//   o_stall rises until room frees up
// reset (synchronous, active low) clears the pending code point, empties the
//   queue and drops o_valid
module utf16_to_utf8_transcoder
    import u16u8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_code_unit,
    input  logic        i_string_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run
);

    // queue fill status toward both sides
    t_q_stat q_stat;
    // completed code points from the front
    logic    push;
    t_cp     push_cp;
    // head of the queue into the serializer
    logic    pop;
    t_cp     head_cp;

    u16u8_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_code_unit  (i_code_unit),
        .i_string_end (i_string_end),
        .i_q_stat     (q_stat),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_push_cp    (push_cp)
    );

    u16u8_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_cp (push_cp),
        .i_pop     (pop),
        .o_head_cp (head_cp),
        .o_q_stat  (q_stat)
    );

    u16u8_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (q_stat),
        .i_head_cp     (head_cp),
        .i_stall       (i_stall),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule
